// File: rtl/load_cell_temp_compensation_macros.svh
// Assertion helpers used by the checker file.
`ifndef LOAD_CELL_TEMP_COMPENSATION_MACROS_SVH
`define LOAD_CELL_TEMP_COMPENSATION_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ltc_pkg.sv
`default_nettype none

package ltc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int TEMP_W   = 19;
  localparam int GAIN_W   = 18;
  localparam int TAU_W    = 24;
  localparam int INTV_W   = 24;
  localparam int WEIGHT_W = 32;

  localparam int ALPHA_W = FRAC_BITS + 1;
  localparam int DEN_W   = TAU_W + 1;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int FPROD_W = ERR_W + ALPHA_W + 1;
  localparam int CPROD_W = GAIN_W + ERR_W;
  localparam int MAG_W   = CPROD_W - 1;
  localparam int SUM_W   = MAG_W + 2;
  localparam int CNT_W   = $clog2(ALPHA_W + 1);

  // |gain * diff| stays below 2^36, so floor(m / 1000) equals
  // floor((m >> 3) * CORR_RECIP / 2^40), done as two half-width products
  localparam int CORR_PRE  = 3;
  localparam int X_W       = MAG_W - CORR_PRE;
  localparam int HALF_W    = X_W / 2;
  localparam int REC_W     = 34;
  localparam int PP_W      = HALF_W + REC_W;
  localparam int PROD_W    = X_W + REC_W;
  localparam int REC_SHIFT = 40;
  localparam int QUO_W     = PROD_W - REC_SHIFT;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAU  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF  = 2'd2;

  localparam logic ACT_RESTART = 1'b1;

  localparam logic [TAU_W-1:0]   TAU_RESET  = 24'd1500;
  localparam logic [REC_W-1:0]   CORR_RECIP = 34'd8796093023;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADIV,
    S_FMUL,
    S_FUPD,
    S_DIFF,
    S_CMUL,
    S_CLOAD,
    S_CMLO,
    S_CMHI,
    S_SUM
  } ltc_state_t;

  typedef struct packed {
    logic load_in;
    logic restart;
    logic seed;
    logic alpha_load;
    logic filt_mul;
    logic filt_upd;
    logic corr_diff;
    logic corr_mul;
    logic corr_load;
    logic corr_mlo;
    logic corr_mhi;
    logic div_step;
    logic load_out;
  } ltc_cmd_t;

  typedef struct packed {
    logic restart_item;
    logic seeded;
    logic den_zero;
    logic div_last;
  } ltc_sts_t;

endpackage

`default_nettype wire

// File: rtl/ltc_if.sv
`default_nettype none

interface ltc_in_if import ltc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [WEIGHT_W-1:0] raw_weight_mg;
  logic signed [TEMP_W-1:0]   temp_mdeg;
  logic [INTV_W-1:0]          interval_s;

  modport source (output valid, action, raw_weight_mg, temp_mdeg, interval_s, input ready);
  modport sink   (input valid, action, raw_weight_mg, temp_mdeg, interval_s, output ready);
endinterface

interface ltc_out_if import ltc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] compensated_weight_mg;
  logic signed [TEMP_W-1:0]   filtered_temp_mdeg;

  modport source (output valid, compensated_weight_mg, filtered_temp_mdeg, input ready);
  modport sink   (input valid, compensated_weight_mg, filtered_temp_mdeg, output ready);
endinterface

`default_nettype wire

// File: rtl/ltc_ctrl.sv
`default_nettype none

module ltc_ctrl import ltc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ltc_sts_t sts,
  output ltc_cmd_t cmd
);

  ltc_state_t state;
  ltc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.restart_item) begin
          cmd.restart = 1'b1;
          state_next  = S_IDLE;
        end else if (!sts.seeded) begin
          cmd.seed   = 1'b1;
          state_next = S_DIFF;
        end else begin
          cmd.alpha_load = 1'b1;
          state_next     = sts.den_zero ? S_FMUL : S_ADIV;
        end
      end
      S_ADIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FMUL;
        end
      end
      S_FMUL: begin
        cmd.filt_mul = 1'b1;
        state_next   = S_FUPD;
      end
      S_FUPD: begin
        cmd.filt_upd = 1'b1;
        state_next   = S_DIFF;
      end
      S_DIFF: begin
        cmd.corr_diff = 1'b1;
        state_next    = S_CMUL;
      end
      S_CMUL: begin
        cmd.corr_mul = 1'b1;
        state_next   = S_CLOAD;
      end
      S_CLOAD: begin
        cmd.corr_load = 1'b1;
        state_next    = S_CMLO;
      end
      S_CMLO: begin
        cmd.corr_mlo = 1'b1;
        state_next   = S_CMHI;
      end
      S_CMHI: begin
        cmd.corr_mhi = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ltc_dp.sv
`default_nettype none

module ltc_dp import ltc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  ltc_cmd_t                   cmd,
  output ltc_sts_t                   sts,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_action,
  input  logic signed [WEIGHT_W-1:0] in_raw,
  input  logic signed [TEMP_W-1:0]   in_temp,
  input  logic [INTV_W-1:0]          in_interval,
  output logic signed [WEIGHT_W-1:0] out_weight,
  output logic signed [TEMP_W-1:0]   out_temp
);

  // configuration
  logic signed [GAIN_W-1:0] gain;
  logic [TAU_W-1:0]         tau;
  logic signed [TEMP_W-1:0] ref_temp;

  // filter state
  logic signed [TEMP_W-1:0] eff;
  logic                     seeded;

  // captured item
  logic                       action_q;
  logic signed [WEIGHT_W-1:0] raw;
  logic signed [TEMP_W-1:0]   temp;
  logic [INTV_W-1:0]          interval;

  // arithmetic
  logic signed [ERR_W-1:0]   err;
  logic signed [FPROD_W-1:0] fprod;
  logic signed [ERR_W-1:0]   diff;
  logic signed [CPROD_W-1:0] cprod;
  logic                      neg;

  // restoring divider for alpha
  logic [DEN_W-1:0]   div_rem;
  logic [DEN_W-1:0]   div_den;
  logic [ALPHA_W-1:0] div_num;
  logic [ALPHA_W-1:0] div_quo;
  logic [CNT_W-1:0]   div_cnt;

  // reciprocal multiply for the divide by 1000
  logic [MAG_W-1:0]  mag;
  logic [X_W-1:0]    corr_x;
  logic [HALF_W-1:0] mul_op;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] corr_acc;

  logic [DEN_W:0]            rem_sh;
  logic [DEN_W:0]            rem_sub;
  logic                      ge;
  logic                      den_zero;
  logic [ALPHA_W-1:0]        alpha;
  logic signed [FPROD_W-1:0] upd_sum;
  logic signed [CPROD_W-1:0] cprod_neg;
  logic signed [SUM_W-1:0]   raw_ext;
  logic signed [SUM_W-1:0]   q_ext;
  logic signed [SUM_W-1:0]   wsum;
  logic signed [WEIGHT_W-1:0] wsat;

  assign rem_sh  = {div_rem, div_num[ALPHA_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_den};
  assign ge      = rem_sh >= {1'b0, div_den};

  assign den_zero = (interval == '0) && (tau == '0);
  assign alpha    = den_zero ? ALPHA_ONE : div_quo;

  assign upd_sum   = FPROD_W'(eff) + (fprod >>> FRAC_BITS);
  assign cprod_neg = -cprod;
  assign mag       = cprod[CPROD_W-1] ? cprod_neg[MAG_W-1:0] : cprod[MAG_W-1:0];

  assign mul_op = cmd.corr_mhi ? corr_x[X_W-1:HALF_W] : corr_x[HALF_W-1:0];
  assign pp     = PP_W'(mul_op) * PP_W'(CORR_RECIP);

  assign raw_ext = SUM_W'(raw);
  assign q_ext   = $signed({{(SUM_W-QUO_W){1'b0}}, corr_acc[PROD_W-1:REC_SHIFT]});
  assign wsum    = neg ? (raw_ext - q_ext) : (raw_ext + q_ext);

  // saturate when the upper bits are not a plain sign extension
  always_comb begin
    if (wsum[SUM_W-1:WEIGHT_W-1] == '0 || wsum[SUM_W-1:WEIGHT_W-1] == '1) begin
      wsat = wsum[WEIGHT_W-1:0];
    end else if (wsum[SUM_W-1]) begin
      wsat = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      wsat = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  end

  assign sts.restart_item = (action_q == ACT_RESTART);
  assign sts.seeded       = seeded;
  assign sts.den_zero     = den_zero;
  assign sts.div_last     = (div_cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= '0;
      tau      <= TAU_RESET;
      ref_temp <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN: gain     <= cfg_data[GAIN_W-1:0];
        REG_TAU:  tau      <= cfg_data[TAU_W-1:0];
        REG_REF:  ref_temp <= cfg_data[TEMP_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff    <= '0;
      seeded <= 1'b0;
    end else if (cmd.restart) begin
      eff    <= '0;
      seeded <= 1'b0;
    end else if (cmd.seed) begin
      eff    <= temp;
      seeded <= 1'b1;
    end else if (cmd.filt_upd) begin
      eff <= upd_sum[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_q <= in_action;
      raw      <= in_raw;
      temp     <= in_temp;
      interval <= in_interval;
    end
    if (cmd.alpha_load) begin
      err <= ERR_W'(temp) - ERR_W'(eff);
    end
    if (cmd.filt_mul) begin
      fprod <= err * $signed({1'b0, alpha});
    end
    if (cmd.corr_diff) begin
      diff <= ERR_W'(eff) - ERR_W'(ref_temp);
    end
    if (cmd.corr_mul) begin
      cprod <= gain * diff;
    end
    if (cmd.corr_load) begin
      neg    <= cprod[CPROD_W-1];
      corr_x <= X_W'(mag >> CORR_PRE);
    end
    // low half product first, then add the high half shifted into place
    if (cmd.corr_mlo) begin
      corr_acc <= PROD_W'(pp);
    end else if (cmd.corr_mhi) begin
      corr_acc <= corr_acc + {pp, {HALF_W{1'b0}}};
    end
    if (cmd.load_out) begin
      out_weight <= wsat;
      out_temp   <= eff;
    end
  end

  // alpha: interval is at most the denominator, so start with interval >> 1
  // in the remainder and its low bit as the next numerator bit
  always_ff @(posedge clk) begin
    if (cmd.alpha_load) begin
      div_rem <= DEN_W'(interval >> 1);
      div_num <= {interval[0], {(ALPHA_W-1){1'b0}}};
      div_den <= DEN_W'(interval) + DEN_W'(tau);
      div_cnt <= CNT_W'(ALPHA_W);
    end else if (cmd.div_step) begin
      div_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      div_num <= {div_num[ALPHA_W-2:0], 1'b0};
      div_quo <= {div_quo[ALPHA_W-2:0], ge};
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/load_cell_temp_compensation.sv
// Channel  | Dir | Fields
// ---------+-----+------------------------------------------------------------
// sample   | in  | action, raw_weight_mg, temp_mdeg, interval_s
// result   | out | compensated_weight_mg, filtered_temp_mdeg
// cfg      | in  | cfg_we, cfg_index, cfg_data (gain, time constant, reference)
//
// One sample at a time. A filtered sample runs 17 steps of the bit-serial
// divider for alpha, then the filter update and the correction; the divide by
// 1000 is a reciprocal multiply done as a low and a high half-width product.
// A zero denominator skips the divider; seeding skips the filter; restart clears it.
// Synchronous active-high reset clears the filter state and loads the register
// defaults. A stalled result sits in the output register while the next
// sample is accepted; the block holds only at the final sum.
`default_nettype none

module load_cell_temp_compensation import ltc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ltc_in_if.sink                sample,
  ltc_out_if.source             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ltc_cmd_t cmd;
  ltc_sts_t sts;

  ltc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ltc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_action   (sample.action),
    .in_raw      (sample.raw_weight_mg),
    .in_temp     (sample.temp_mdeg),
    .in_interval (sample.interval_s),
    .out_weight  (result.compensated_weight_mg),
    .out_temp    (result.filtered_temp_mdeg)
  );

endmodule

`default_nettype wire

// File: rtl/ltc_checker.sv
`default_nettype none
`include "load_cell_temp_compensation_macros.svh"

module ltc_checker import ltc_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       sample_valid,
  input logic                       sample_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic signed [WEIGHT_W-1:0] result_weight,
  input logic signed [TEMP_W-1:0]   result_temp
);

  `LTC_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result_valid, "result valid after reset")

  `LTC_ASSERT(a_result_holds, result_valid && !result_ready |=> result_valid && $stable(result_weight) && $stable(result_temp), "stalled result changed")

  `LTC_ASSERT(a_one_at_a_time, sample_valid && sample_ready |=> !sample_ready, "sample taken while busy")

  `LTC_ASSERT(a_no_instant_result, $rose(result_valid) |-> !$past(sample_valid && sample_ready), "result right after accept")

endmodule

bind load_cell_temp_compensation ltc_checker u_ltc_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample.valid),
  .sample_ready  (sample.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_weight (result.compensated_weight_mg),
  .result_temp   (result.filtered_temp_mdeg)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ltc_pkg::*;

  localparam logic ACT_APPLY = 1'b0;
  localparam longint MDEG_PER_K = 1000;
  localparam longint WEIGHT_MAX = 64'sd2147483647;
  localparam longint WEIGHT_MIN = -64'sd2147483648;
  localparam longint BLEND_ONE = 64'sd1 <<< FRAC_BITS;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 141;

  typedef struct {
    logic                       action;
    logic signed [WEIGHT_W-1:0] raw;
    logic signed [TEMP_W-1:0]   temp;
    logic [INTV_W-1:0]          intv;
  } sample_t;

  typedef struct {
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [TEMP_W-1:0]   ftemp;
  } comp_t;

  class comp_scoreboard;
    logic signed [GAIN_W-1:0] gain;
    logic [TAU_W-1:0]         tau;
    logic signed [TEMP_W-1:0] ref_temp;
    logic signed [TEMP_W-1:0] lag_temp;
    bit                       primed;
    comp_t                    expected_weights[$];
    int                       errors;

    function new();
      gain     = '0;
      tau      = TAU_RESET;
      ref_temp = '0;
      lag_temp = '0;
      primed   = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN: gain = data[GAIN_W-1:0];
        REG_TAU:  tau = data[TAU_W-1:0];
        REG_REF:  ref_temp = data[TEMP_W-1:0];
        default: ;
      endcase
    endfunction

    // Q16 weight of the new reading, clipped at one
    function longint blend_factor(logic [INTV_W-1:0] intv);
      longint den;
      longint num;
      longint a;
      den = intv;
      den += tau;
      if (den == 0) return BLEND_ONE;
      num = intv;
      a = (num <<< FRAC_BITS) / den;
      return (a > BLEND_ONE) ? BLEND_ONE : a;
    endfunction

    function void note_sample(sample_t s);
      longint err;
      longint corr;
      longint w;
      comp_t  c;
      if (s.action == ACT_RESTART) begin
        lag_temp = '0;
        primed   = 1'b0;
        return;
      end
      if (!primed) begin
        lag_temp = s.temp;
        primed   = 1'b1;
      end else begin
        err = longint'(s.temp) - longint'(lag_temp);
        // arithmetic shift of a signed product floors toward minus infinity
        lag_temp = TEMP_W'(longint'(lag_temp) + ((err * blend_factor(s.intv)) >>> FRAC_BITS));
      end
      corr = (longint'(gain) * (longint'(lag_temp) - longint'(ref_temp))) / MDEG_PER_K;
      w = longint'(s.raw) + corr;
      if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      if (w < WEIGHT_MIN) w = WEIGHT_MIN;
      c.weight = w[WEIGHT_W-1:0];
      c.ftemp  = lag_temp;
      expected_weights.push_back(c);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic signed [WEIGHT_W-1:0] weight, logic signed [TEMP_W-1:0] ftemp);
      comp_t c;
      if (expected_weights.size() == 0) begin
        report("unexpected result, weight", weight, 0);
        return;
      end
      c = expected_weights.pop_front();
      if (weight !== c.weight) report("compensated_weight_mg", weight, c.weight);
      if (ftemp !== c.ftemp) report("filtered_temp_mdeg", ftemp, c.ftemp);
    endtask

    function int pending();
      return expected_weights.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;
  comp_scoreboard        comp_sb;

  ltc_in_if  sample_ch ();
  ltc_out_if result_ch ();

  load_cell_temp_compensation u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic sample_t mk(logic act, logic signed [WEIGHT_W-1:0] raw,
                                 logic signed [TEMP_W-1:0] temp, logic [INTV_W-1:0] intv);
    sample_t s;
    s.action = act;
    s.raw    = raw;
    s.temp   = temp;
    s.intv   = intv;
    return s;
  endfunction

  function automatic sample_t make_sample();
    sample_t s;
    s.action = ($urandom_range(0, 24) == 0) ? ACT_RESTART : ACT_APPLY;
    case ($urandom_range(0, 5))
      0:       s.raw = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1:       s.raw = int'($urandom_range(0, 2000)) - 1000;
      default: s.raw = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       s.temp = $urandom_range(0, 1) ? 19'sd262143 : -19'sd262144;
      1:       s.temp = int'($urandom_range(0, 4000)) - 2000;
      default: s.temp = $urandom_range(0, (1 << TEMP_W) - 1);
    endcase
    case ($urandom_range(0, 5))
      0:       s.intv = '0;
      1:       s.intv = $urandom_range(1, 100);
      2:       s.intv = $urandom_range(0, 5000);
      3:       s.intv = {INTV_W{1'b1}};
      default: s.intv = $urandom_range(0, (1 << INTV_W) - 1);
    endcase
    return s;
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 4))
      0:       return -131072;
      1:       return 131071;
      2:       return 0;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int pick_tau();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 1500;
      3:       return 16777215;
      4:       return $urandom_range(0, 5000);
      default: return $urandom_range(0, 16777215);
    endcase
  endfunction

  function automatic int pick_ref();
    case ($urandom_range(0, 4))
      0:       return -262144;
      1:       return 262143;
      2:       return 0;
      default: return int'($urandom_range(0, 524287)) - 262144;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    comp_sb.write_reg(idx, value[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(sample_t s);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.action        <= s.action;
    sample_ch.raw_weight_mg <= s.raw;
    sample_ch.temp_mdeg     <= s.temp;
    sample_ch.interval_s    <= s.intv;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    comp_sb.note_sample(s);
  endtask

  // hold off until every result is out and a trailing restart has finished
  task automatic quiesce();
    sample_ch.valid <= 1'b0;
    while (comp_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    bit rdy;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        comp_sb.check_result(result_ch.compensated_weight_mg, result_ch.filtered_temp_mdeg);
      rdy = 1'b1;
      if (stall > 0) begin
        stall--;
        rdy = 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        rdy = 1'b0;
      end
      result_ch.ready <= rdy;
    end
  end

  initial begin : stimulus
    comp_sb = new();
    rst = 1'b1;
    calm = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.action = ACT_APPLY;
    sample_ch.raw_weight_mg = '0;
    sample_ch.temp_mdeg = '0;
    sample_ch.interval_s = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_GAIN, 131071);
    write_reg(REG_TAU, 1500);
    write_reg(REG_REF, 0);
    // seed at the hot end; the correction drives the weight into positive saturation
    send_sample(mk(ACT_APPLY, 32'sh7fff_ffff, 262143, 0));
    send_sample(mk(ACT_APPLY, 32'sh8000_0000, -262144, 16777215));
    send_sample(mk(ACT_APPLY, 0, 262143, 0));
    send_sample(mk(ACT_APPLY, -1, 1000, 1500));
    send_sample(mk(ACT_APPLY, 1, -1, 1));
    send_sample(mk(ACT_RESTART, 0, 0, 0));
    send_sample(mk(ACT_RESTART, 32'sh7fff_ffff, -262144, 16777215));
    send_sample(mk(ACT_APPLY, 12345, -262144, 16777215));
    send_sample(mk(ACT_APPLY, 0, 262143, 3000));

    // zero time constant: a zero interval still takes the full step
    quiesce();
    write_reg(REG_TAU, 0);
    send_sample(mk(ACT_APPLY, 0, 100, 0));
    send_sample(mk(ACT_APPLY, 0, -5000, 7));
    send_sample(mk(ACT_APPLY, 0, 262143, 16777215));

    quiesce();
    write_reg(REG_GAIN, -131072);
    write_reg(REG_TAU, 16777215);
    write_reg(REG_REF, 262143);
    send_sample(mk(ACT_APPLY, 32'sh7fff_ffff, -262144, 16777215));
    send_sample(mk(ACT_APPLY, 32'sh8000_0000, -262144, 0));
    send_sample(mk(ACT_RESTART, 0, 0, 0));
    send_sample(mk(ACT_APPLY, 32'sh8000_0000, 262143, 5));

    // small gain: the divide by 1000 must truncate toward zero
    quiesce();
    write_reg(REG_GAIN, 1);
    write_reg(REG_REF, -262144);
    send_sample(mk(ACT_APPLY, 0, 262143, 1));
    quiesce();
    write_reg(REG_REF, 0);
    send_sample(mk(ACT_RESTART, 0, 0, 0));
    send_sample(mk(ACT_APPLY, 0, -999, 0));
    send_sample(mk(ACT_APPLY, 0, -1999, 0));
    send_sample(mk(ACT_APPLY, 0, 1999, 16777215));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiesce();
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      write_reg(REG_GAIN, pick_gain());
      write_reg(REG_TAU, pick_tau());
      write_reg(REG_REF, pick_ref());
      repeat (PHASE_ITEMS) send_sample(make_sample());
    end

    sample_ch.valid <= 1'b0;
    while (comp_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (comp_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ltc_pkg.sv
rtl/ltc_if.sv
rtl/ltc_ctrl.sv
rtl/ltc_dp.sv
rtl/load_cell_temp_compensation.sv
rtl/ltc_checker.sv
tb/sv/tb.sv
